// ===== rtl/core/min_priority_queue_core_macros.svh =====
// Assertion macros shared by the queue checker.
// No dependencies; include by bare file name.
`ifndef MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mpq_pkg.sv =====
// Shared types and codes for the min priority queue core.
// No dependencies; imported by every module of the core.
`default_nettype none

package mpq_pkg;

    localparam int MPQ_DEPTH = 8;
    localparam int DATA_W    = 32;
    localparam int PRIO_W    = 16;
    localparam int OCC_W     = 4;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } mpq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpq_cell.sv =====
// One slot of the sorted cell row: holds a (data, priority) pair.
// Depends on mpq_pkg for widths and the control struct.
`default_nettype none

module mpq_cell (
    input  wire logic                      aclk,
    input  wire mpq_pkg::mpq_ctl_t         ctl,
    input  wire logic                      occupied,
    input  wire logic                      left_ins,
    input  wire logic [mpq_pkg::DATA_W-1:0] left_data,
    input  wire logic [mpq_pkg::PRIO_W-1:0] left_prio,
    input  wire logic [mpq_pkg::DATA_W-1:0] right_data,
    input  wire logic [mpq_pkg::PRIO_W-1:0] right_prio,
    output logic                           ins,
    output logic [mpq_pkg::DATA_W-1:0]     data_o,
    output logic [mpq_pkg::PRIO_W-1:0]     prio_o
);
    import mpq_pkg::*;

    logic [DATA_W-1:0] data_reg, data_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;

    // New item belongs here or earlier; equal priorities stay ahead of it.
    assign ins = !occupied || ($signed(ctl.prio) < $signed(prio_reg));

    always_comb begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctl.enq) begin
            if (left_ins) begin
                // make room: take the neighbor's entry
                data_next = left_data;
                prio_next = left_prio;
            end else if (ins) begin
                data_next = ctl.data;
                prio_next = ctl.prio;
            end
        end else if (ctl.deq) begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data_o = data_reg;
    assign prio_o = prio_reg;

endmodule

`default_nettype wire

// ===== rtl/core/min_priority_queue_core.sv =====
// Bounded min priority queue over a row of DEPTH cells kept sorted by priority,
// earliest arrival first among equals. A new command transaction is accepted
// every cycle the result register is free or drained, and its result appears
// on the m_ side on the next cycle. The clock cycle is set by the priority
// compare that is broadcast across the cell row, one 16-bit compare per cell
// in parallel. No clearing pass after reset.
`default_nettype none

module min_priority_queue_core #(
    parameter int DEPTH = mpq_pkg::MPQ_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [31:0] item_data, [47:32] item_priority
    input  wire logic [mpq_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [31:0] out_data, [47:32] out_priority, [51:48] occupancy, [55:52] zero
    output logic [mpq_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [mpq_pkg::STAT_W-1:0]        m_tuser
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] odata_reg, odata_next;
    logic [PRIO_W-1:0] oprio_reg, oprio_next;
    logic [OCC_W-1:0]  occ_reg;

    logic              accept, full, empty;
    logic [CNT_W+OCC_W-1:0] count_ext;
    mpq_ctl_t          ctl;

    logic              ins_w  [DEPTH];
    logic [DATA_W-1:0] data_w [DEPTH];
    logic [PRIO_W-1:0] prio_w [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign ctl.enq  = accept && (s_tuser == CMD_ENQ) && !full;
    assign ctl.deq  = accept && (s_tuser == CMD_DEQ) && !empty;
    assign ctl.data = s_tdata[DATA_W-1:0];
    assign ctl.prio = s_tdata[DATA_W+PRIO_W-1:DATA_W];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              left_ins;
        logic [DATA_W-1:0] left_data, right_data;
        logic [PRIO_W-1:0] left_prio, right_prio;

        if (i == 0) begin : g_head
            assign left_ins  = 1'b0;
            assign left_data = '0;
            assign left_prio = '0;
        end else begin : g_mid
            assign left_ins  = ins_w[i-1];
            assign left_data = data_w[i-1];
            assign left_prio = prio_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data = '0;
            assign right_prio = '0;
        end else begin : g_body
            assign right_data = data_w[i+1];
            assign right_prio = prio_w[i+1];
        end

        mpq_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .occupied   (CNT_W'(i) < count_reg),
            .left_ins   (left_ins),
            .left_data  (left_data),
            .left_prio  (left_prio),
            .right_data (right_data),
            .right_prio (right_prio),
            .ins        (ins_w[i]),
            .data_o     (data_w[i]),
            .prio_o     (prio_w[i])
        );
    end

    always_comb begin
        count_next  = count_reg;
        status_next = ST_INSERTED;
        odata_next  = '0;
        oprio_next  = '0;
        if (s_tuser == CMD_ENQ) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                // head of the sorted row is the minimum
                status_next = ST_REMOVED;
                odata_next  = data_w[0];
                oprio_next  = prio_w[0];
                count_next  = count_reg - 1'b1;
            end
        end
    end

    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            odata_reg  <= odata_next;
            oprio_reg  <= oprio_next;
            occ_reg    <= count_ext[OCC_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - PRIO_W - OCC_W){1'b0}},
                       occ_reg, oprio_reg, odata_reg};

endmodule

`default_nettype wire

// ===== rtl/core/mpq_checker.sv =====
// Port-level checks for min_priority_queue_core, bound to the top level.
// Depends on mpq_pkg and min_priority_queue_core_macros.svh.
`default_nettype none

`include "min_priority_queue_core_macros.svh"

module mpq_checker #(
    parameter int DEPTH = mpq_pkg::MPQ_DEPTH
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mpq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [mpq_pkg::STAT_W-1:0]    m_tuser
);
    import mpq_pkg::*;

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // a stalled result holds its transaction
    `MPQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    // result register full and stalled: no new command transaction
    `MPQ_ASSERT_NOW(a_backpressure, m_tvalid && !m_tready, !s_tready, "command taken while result stalled")
    // a rejected insert reports a full queue
    `MPQ_ASSERT_NOW(a_full_occ, m_tvalid && (m_tuser == ST_FULL), m_tdata[DATA_W+PRIO_W+OCC_W-1:DATA_W+PRIO_W] == FULL_OCC, "full status with wrong occupancy")
    // no removal: empty queue and no payload
    `MPQ_ASSERT_NOW(a_empty_zero, m_tvalid && (m_tuser == ST_EMPTY), m_tdata == '0, "empty status with nonzero fields")

endmodule

bind min_priority_queue_core mpq_checker #(.DEPTH(DEPTH)) u_mpq_checker (.*);

`default_nettype wire
